// ===== hw/rtl/lkt_pkg.sv =====
// ----------------------------------------------------------------------------
// lkt_pkg: shared types and constants for the LRU key tracker
// Status codes, sequencer states and the control bundle sent to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lkt_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 32;
	localparam int KEY_W        = 32;   // key field width on the streams
	localparam int STATUS_W     = 2;

	typedef enum logic [STATUS_W-1:0] {
		STAT_TOUCHED = 2'd0,
		STAT_EVICTED = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		CMD_TOUCH = 1'b0,
		CMD_EVICT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_LOOK   = 2'd1,
		S_UPDATE = 2'd2
	} state_t;

	// broadcast to all cells
	typedef struct packed {
		logic look;     // capture compare flags
		logic update;   // apply the item
		logic evict;    // item is an evict
		logic hit_any;  // some cell matched the key
		logic space;    // at least one free cell
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lru_key_tracker.sv =====
// ----------------------------------------------------------------------------
// lru_key_tracker: least-recently-used replacement tracker
// A row of slot cells keeps keys and age ranks; touch refreshes or inserts a
// key, evict removes and returns the oldest key.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser[0]=cmd, tdata[31:0]=key
//   m_*      out  m_tvalid/m_tready  tuser[1:0]=status, tdata[31:0]=evicted_key
//
// Steps per item: accept, compare in every cell, then update and load the
// output register. The result register lets the next item be taken while a
// result waits; the update step holds while that register is full and
// m_tready is low.
// Reset asynchronously clears all valid bits, ranks and the occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_tracker #(
	parameter int ENTRIES  = lkt_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = lkt_pkg::KEY_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [lkt_pkg::KEY_W-1:0]     s_tdata,   // key
	input  wire  [0:0]                    s_tuser,   // cmd
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [lkt_pkg::KEY_W-1:0]     m_tdata,   // evicted_key
	output logic [lkt_pkg::STATUS_W-1:0]  m_tuser    // status
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	// key bits that pass between the stream field and the stored key
	localparam int CW     = (KEY_BITS < lkt_pkg::KEY_W) ? KEY_BITS : lkt_pkg::KEY_W;

	lkt_pkg::state_t   state_q, state_d;
	lkt_pkg::cmd_t     cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [OCC_W-1:0]  occ_q;

	logic                out_valid_q;
	lkt_pkg::status_t    out_status_q;
	logic [lkt_pkg::KEY_W-1:0] out_key_q;

	lkt_pkg::cell_ctl_t  ctl;
	logic                accept;
	logic                commit;

	// cell row outputs
	logic [ENTRIES:0]    free_chain;
	logic [ENTRIES-1:0]  match_vec;
	logic [ENTRIES-1:0]  oldest_vec;
	logic [ENTRIES-1:0]  valid_vec;
	logic [RANK_W-1:0]   rank_arr [ENTRIES];
	logic [KEY_BITS-1:0] key_arr  [ENTRIES];

	logic [RANK_W-1:0]   hit_rank;
	logic [KEY_BITS-1:0] evk;
	logic [RANK_W-1:0]   last_rank;

	assign accept    = s_tvalid && s_tready;
	assign last_rank = RANK_W'(occ_q - 1'b1);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lkt_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		commit   = 1'b0;
		case (state_q)
			lkt_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = lkt_pkg::S_LOOK;
			end
			lkt_pkg::S_LOOK: begin
				state_d = lkt_pkg::S_UPDATE;
			end
			lkt_pkg::S_UPDATE: begin
				// only when the result register can take the result
				if (!out_valid_q || m_tready) begin
					commit  = 1'b1;
					state_d = lkt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lkt_pkg::S_IDLE;
			end
		endcase
	end

	// item capture, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= lkt_pkg::cmd_t'(s_tuser[0]);
			key_q <= KEY_BITS'(s_tdata[CW-1:0]);
		end
	end

	// ---- reductions across the row (at most one match, one oldest) ----
	always_comb begin
		hit_rank = '0;
		evk      = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i])
				hit_rank = hit_rank | rank_arr[i];
			if (oldest_vec[i])
				evk = evk | key_arr[i];
		end
	end

	assign ctl.look    = (state_q == lkt_pkg::S_LOOK);
	assign ctl.update  = commit;
	assign ctl.evict   = (cmd_q == lkt_pkg::CMD_EVICT);
	assign ctl.hit_any = |match_vec;
	assign ctl.space   = free_chain[ENTRIES];

	// ---- cell row; the free claim ripples from cell 0 upward ----
	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lkt_cell #(
			.KEY_BITS (KEY_BITS),
			.RANK_W   (RANK_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key       (key_q),
			.hit_rank  (hit_rank),
			.last_rank (last_rank),
			.free_in   (free_chain[g]),
			.free_out  (free_chain[g+1]),
			.match     (match_vec[g]),
			.oldest    (oldest_vec[g]),
			.valid     (valid_vec[g]),
			.rank      (rank_arr[g]),
			.slot_key  (key_arr[g])
		);
	end

	// ---- occupancy ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else if (commit) begin
			if (ctl.evict) begin
				if (|oldest_vec)
					occ_q <= occ_q - 1'b1;
			end else if (!ctl.hit_any && ctl.space)
				occ_q <= occ_q + 1'b1;
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (ctl.evict) begin
				if (|oldest_vec) begin
					out_status_q <= lkt_pkg::STAT_EVICTED;
					out_key_q    <= lkt_pkg::KEY_W'(evk[CW-1:0]);
				end else begin
					out_status_q <= lkt_pkg::STAT_EMPTY;
					out_key_q    <= '0;
				end
			end else begin
				out_key_q <= '0;
				if (ctl.hit_any || ctl.space)
					out_status_q <= lkt_pkg::STAT_TOUCHED;
				else
					out_status_q <= lkt_pkg::STAT_FULL;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_key_q;
	assign m_tuser  = out_status_q;

`ifndef SYNTHESIS
	// occupancy tracks the number of valid cells
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(occ_q))
		else $error("occupancy differs from valid cell count");

	// held keys are distinct, so a lookup matches at most one cell
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkt_pkg::S_UPDATE) |-> $onehot0(match_vec))
		else $error("key matched in more than one cell");

	// with a non-empty table, the update step sees exactly one oldest cell
	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkt_pkg::S_UPDATE && occ_q != '0) |-> $onehot(oldest_vec))
		else $error("oldest cell not unique");

	// a committed insert grows occupancy by one
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !ctl.evict && !ctl.hit_any && ctl.space)
			|=> (occ_q == $past(occ_q) + 1'b1))
		else $error("insert did not grow occupancy");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lkt_cell.sv =====
// ----------------------------------------------------------------------------
// lkt_cell: one slot of the LRU key tracker
// Holds a key, a valid bit and an age rank; passes the free-slot claim on.
// ----------------------------------------------------------------------------
`default_nettype none

module lkt_cell #(
	parameter int KEY_BITS = lkt_pkg::KEY_BITS_DEF,
	parameter int RANK_W   = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire lkt_pkg::cell_ctl_t ctl,
	input  wire  [KEY_BITS-1:0]   key,
	input  wire  [RANK_W-1:0]     hit_rank,
	input  wire  [RANK_W-1:0]     last_rank,
	input  wire                   free_in,   // a lower cell is free
	output logic                  free_out,
	output logic                  match,
	output logic                  oldest,
	output logic                  valid,
	output logic [RANK_W-1:0]     rank,
	output logic [KEY_BITS-1:0]   slot_key
);

	logic [KEY_BITS-1:0] key_q;
	logic                valid_q;
	logic [RANK_W-1:0]   rank_q;
	logic                match_q;
	logic                oldest_q;
	logic                first_free;

	assign first_free = !valid_q && !free_in;
	assign free_out   = free_in || !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			rank_q   <= '0;
			match_q  <= 1'b0;
			oldest_q <= 1'b0;
		end else begin
			if (ctl.look) begin
				match_q  <= valid_q && (key_q == key);
				oldest_q <= valid_q && (rank_q == last_rank);
			end
			if (ctl.update) begin
				if (ctl.evict) begin
					if (oldest_q) begin
						valid_q <= 1'b0;
						rank_q  <= '0;
					end
				end else if (ctl.hit_any) begin
					if (match_q)
						rank_q <= '0;
					else if (valid_q && rank_q < hit_rank)
						rank_q <= rank_q + 1'b1;
				end else if (ctl.space) begin
					if (valid_q)
						rank_q <= rank_q + 1'b1;
					else if (first_free) begin
						valid_q <= 1'b1;
						rank_q  <= '0;
					end
				end
			end
		end
	end

	// key store, no reset
	always_ff @(posedge clk) begin
		if (ctl.update && !ctl.evict && !ctl.hit_any && ctl.space && first_free)
			key_q <= key;
	end

	assign match    = match_q;
	assign oldest   = oldest_q;
	assign valid    = valid_q;
	assign rank     = rank_q;
	assign slot_key = key_q;

endmodule

`default_nettype wire

// ===== tb/sv/lru_key_tracker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_tracker_test: self-checking bench for the LRU key tracker
// Drives touch and evict items on the input stream and keeps its own copy of
// the slot table (keys, valid bits, age ranks). Every accepted item is
// predicted at the moment it is taken, and each result on the output stream
// is checked in order against that prediction. Directed cases come first,
// then a long-stall backpressure case, then random traffic, then a drain.
// ----------------------------------------------------------------------------

module lru_key_tracker_test;

	localparam int SLOTS          = lkt_pkg::ENTRIES_DEF;
	localparam int HOLD_CYCLES    = 300;    // long receiver stall
	localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all
	localparam int DRAIN_CYCLES   = 12;     // wait after the last expected result
	localparam int IDLE_PCT       = 27;
	localparam int BURSTS         = 26;
	localparam int BURST_ITEMS    = 50;
	localparam int POOL_SIZE      = 24;     // more keys than slots: hits, misses, full

	typedef struct packed {
		lkt_pkg::status_t status;
		logic [31:0]      evicted_key;
	} lru_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [lkt_pkg::KEY_W-1:0]    s_tdata = '0;      // key
	logic [0:0]                   s_tuser = '0;      // cmd
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [lkt_pkg::KEY_W-1:0]    m_tdata;           // evicted_key
	logic [lkt_pkg::STATUS_W-1:0] m_tuser;           // status

	// tracker copy: per-slot key, valid bit and age rank (0 = most recent)
	logic [31:0] trk_key [SLOTS];
	logic        trk_valid [SLOTS];
	int          trk_rank [SLOTS];
	int          trk_count;

	lru_result_t pending_results[$];
	lru_result_t due;
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          hold_count = 0;
	bit          gaps_on = 1'b1;
	int          hold_req = 0;      // hold-offs asked for by the sender side
	int          hold_done = 0;     // hold-offs finished by the receiver
	logic [31:0] key_pool [POOL_SIZE];

	lru_key_tracker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one item to the tracker copy and return what the block must answer.
	function automatic lru_result_t recency_update(lkt_pkg::cmd_t c, logic [31:0] k);
		lru_result_t r;
		int hit;
		int free_idx;
		int oldest;
		int age;
		r.status      = lkt_pkg::STAT_TOUCHED;
		r.evicted_key = '0;
		hit      = -1;
		free_idx = -1;
		oldest   = -1;
		if (c == lkt_pkg::CMD_TOUCH) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (trk_valid[i] && trk_key[i] == k && hit < 0)
					hit = i;
				if (!trk_valid[i] && free_idx < 0)
					free_idx = i;
			end
			if (hit >= 0) begin
				// refresh: only slots younger than the hit get older
				age = trk_rank[hit];
				for (int i = 0; i < SLOTS; i++)
					if (trk_valid[i] && trk_rank[i] < age)
						trk_rank[i]++;
				trk_rank[hit] = 0;
			end else if (free_idx >= 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (trk_valid[i])
						trk_rank[i]++;
				trk_key[free_idx]   = k;
				trk_valid[free_idx] = 1'b1;
				trk_rank[free_idx]  = 0;
				trk_count++;
			end else begin
				r.status = lkt_pkg::STAT_FULL;   // unseen key, no room: dropped
			end
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (trk_valid[i] && (oldest < 0 || trk_rank[i] > trk_rank[oldest]))
					oldest = i;
			if (oldest < 0) begin
				r.status = lkt_pkg::STAT_EMPTY;
			end else begin
				r.status            = lkt_pkg::STAT_EVICTED;
				r.evicted_key       = trk_key[oldest];
				trk_valid[oldest]   = 1'b0;
				trk_rank[oldest]    = 0;
				trk_count--;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Offer one item; entered and left just after a falling edge.
	task automatic send_item(input lkt_pkg::cmd_t c, input logic [31:0] k);
		while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;   // junk while invalid
			s_tuser  <= 1'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= k;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(recency_update(c, k));
		@(negedge clk);
	endtask

	// Receiver side: random stalls, or one long hold-off when requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_done != hold_req) begin
			m_tready <= 1'b0;
			hold_count++;
			if (hold_count >= HOLD_CYCLES) begin
				hold_count = 0;
				hold_done++;
			end
		end else begin
			m_tready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Result checker: in order, field by field.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d key=%h",
					m_tuser, m_tdata));
			end else begin
				due = pending_results.pop_front();
				if (m_tuser !== due.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						m_tuser, due.status));
				if (m_tdata !== due.evicted_key)
					report_mismatch($sformatf("evicted_key %h, expected %h",
						m_tdata, due.evicted_key));
			end
		end
	end

	// Watchdog: too long without any handshake on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic test_evict_empty();
		send_item(lkt_pkg::CMD_EVICT, $urandom);
	endtask

	task automatic test_touch_extremes();
		send_item(lkt_pkg::CMD_TOUCH, 32'h0000_0000);
		send_item(lkt_pkg::CMD_TOUCH, 32'hFFFF_FFFF);
		send_item(lkt_pkg::CMD_TOUCH, 32'h0000_0000);   // hit, back to most recent
	endtask

	// Fill every slot, then an unseen key is dropped, then a hit on the
	// oldest key still refreshes while full.
	task automatic test_fill_to_full();
		for (int i = 0; i < SLOTS - 2; i++)
			send_item(lkt_pkg::CMD_TOUCH, 32'h8000_0001 << i);
		send_item(lkt_pkg::CMD_TOUCH, 32'h5A5A_A5A5);
		send_item(lkt_pkg::CMD_TOUCH, 32'hFFFF_FFFF);
	endtask

	task automatic test_evict_order();
		repeat (3)
			send_item(lkt_pkg::CMD_EVICT, $urandom);
	endtask

	// Receiver stalls for a long stretch while items keep coming back to back.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_req++;
		for (int i = 0; i < 24; i++)
			send_item(lkt_pkg::cmd_t'(i % 3 == 2), key_pool[i % POOL_SIZE]);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int            evict_pct;
		lkt_pkg::cmd_t c;
		for (int b = 0; b < BURSTS; b++) begin
			case ($urandom_range(0, 3))
				0: evict_pct = 5;
				1: evict_pct = 25;
				2: evict_pct = 50;
				default: evict_pct = 85;
			endcase
			gaps_on = !(b >= 10 && b < 14);   // one long stretch with no idling
			for (int i = 0; i < BURST_ITEMS; i++) begin
				c = ($urandom_range(0, 99) < evict_pct) ? lkt_pkg::CMD_EVICT
					: lkt_pkg::CMD_TOUCH;
				if (c == lkt_pkg::CMD_EVICT || $urandom_range(0, 99) < 20)
					send_item(c, $urandom);
				else
					send_item(c, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
			end
		end
		gaps_on = 1'b1;
	endtask

	// Empty the tracker, then one evict on the empty table.
	task automatic test_drain();
		int left;
		left = trk_count;
		repeat (left + 1)
			send_item(lkt_pkg::CMD_EVICT, $urandom);
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			trk_key[i]   = '0;
			trk_valid[i] = 1'b0;
			trk_rank[i]  = 0;
		end
		trk_count = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_evict_empty();
		test_touch_extremes();
		test_fill_to_full();
		test_evict_order();
		test_backpressure();
		test_random_traffic();
		test_drain();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lkt_pkg.sv
hw/rtl/lkt_cell.sv
hw/rtl/lru_key_tracker.sv
tb/sv/lru_key_tracker_test.sv
